FILE: sv/iptp_pkg.sv
`default_nettype none
package iptp_pkg;
    localparam logic [7:0] CH_COLON = 8'd58;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BAD   = 2'd1;
    localparam logic [1:0] ST_FAM   = 2'd2;
    localparam logic [1:0] FAM_V4   = 2'd0;
    localparam logic [1:0] FAM_V6   = 2'd1;
    localparam int QDEPTH = 2;

    typedef enum logic [7:0] {
        PH_START     = 8'b0000_0001,
        PH_V6_BEGIN  = 8'b0000_0010,
        PH_V6_LEAD   = 8'b0000_0100,
        PH_V6_GAP    = 8'b0000_1000,
        PH_V6_DIGITS = 8'b0001_0000,
        PH_V6_COLON  = 8'b0010_0000,
        PH_V4_DOT    = 8'b0100_0000,
        PH_V4_DIGITS = 8'b1000_0000
    } t_phase;

    // one beat of the queue: a classified character
    typedef struct packed {
        logic [7:0] ch;
        logic [4:0] hex;     // 16 = not a hex digit
        logic       dig;
        logic       colon;
        logic       dot;
        logic       last;
        logic [1:0] family;
    } t_tok;

    function automatic logic part_ok(input logic [9:0] v, input logic [2:0] n);
        logic r;
        r = 1'b1;
        if (n < 3'd1 || n > 3'd3 || v > 10'd255) r = 1'b0;
        if (n == 3'd2 && v < 10'd10) r = 1'b0;
        if (n == 3'd3 && v < 10'd100) r = 1'b0;
        return r;
    endfunction
endpackage
`default_nettype wire

FILE: sv/iptp_front.sv
`default_nettype none
module iptp_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire  [7:0]          i_character,
    input  wire                 i_text_end,
    input  wire  [1:0]          i_family,
    input  wire                 i_valid,
    output logic                o_ready,
    output iptp_pkg::t_tok      o_tok,
    output logic                o_tok_valid,
    input  wire                 i_tok_ready
);
    iptp_pkg::t_tok r_q [iptp_pkg::QDEPTH];
    logic [0:0] r_wp, r_rp;
    logic [1:0] r_cnt;
    iptp_pkg::t_tok w_tok;
    logic w_push, w_pop;
    logic [7:0] w_lc;

    always_comb begin
        w_lc = i_character | 8'd32;
        w_tok.ch = i_character;
        w_tok.dig = (i_character >= 8'd48) && (i_character <= 8'd57);
        if (w_tok.dig) w_tok.hex = 5'(i_character - 8'd48);
        else if (w_lc >= 8'd97 && w_lc <= 8'd102) w_tok.hex = 5'(w_lc - 8'd87);
        else w_tok.hex = 5'd16;
        w_tok.colon = (i_character == iptp_pkg::CH_COLON);
        w_tok.dot = (i_character == iptp_pkg::CH_DOT);
        w_tok.last = i_text_end;
        w_tok.family = i_family;
    end

    assign o_ready = (r_cnt != 2'(iptp_pkg::QDEPTH));
    assign o_tok_valid = (r_cnt != 2'd0);
    assign o_tok = r_q[r_rp];
    assign w_push = i_valid && o_ready;
    assign w_pop = o_tok_valid && i_tok_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_tok;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(iptp_pkg::QDEPTH)) else $error("queue overflow");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> r_cnt == $past(r_cnt) + 2'd1) else $error("count");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> (r_wp == r_rp)) else $error("pointers");
`endif
endmodule
`default_nettype wire

FILE: sv/iptp_back.sv
`default_nettype none
module iptp_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  iptp_pkg::t_tok      i_tok,
    input  wire                 i_tok_valid,
    output logic                o_tok_ready,
    output logic [1:0]          o_status,
    output logic [63:0]         o_address_high,
    output logic [63:0]         o_address_low,
    output logic                o_valid,
    input  wire                 i_ready
);
    logic [15:0] r_grp [8];
    logic [7:0]  r_oct [3];
    iptp_pkg::t_phase r_ph, w_ph, n_ph;
    logic [3:0] r_gc, n_gc, r_gp, n_gp;
    logic r_gv, n_gv, r_err, n_err, r_ad, n_ad;
    logic [15:0] r_hex, n_hex;
    logic [9:0] r_dec, n_dec;
    logic [2:0] r_dc, n_dc, r_oi, n_oi;
    logic [1:0] r_fam, w_fam;
    logic w_go, w_gw, w_ow;
    logic [2:0] w_gi;
    logic [1:0] w_oidx;
    logic [7:0] w_oval;
    // finish stage: grouped snapshot, address assembled next cycle
    logic r_fv, n_fv;
    logic [1:0] r_fst, n_fst;
    logic [15:0] r_fg [8];
    logic [15:0] w_fg [8];
    logic [3:0] r_fgc, r_fgp, n_fgc;
    logic r_fgv, r_f4;
    logic [31:0] r_v4, w_v4;
    logic [127:0] w_addr;
    logic w_fin_ok;
    logic [3:0] w_fill, w_j;
    logic w_adv;

    assign w_adv = !o_valid || i_ready;
    // only a text_end beat needs the finish register free
    assign o_tok_ready = w_adv || !i_tok.last;
    assign w_go = i_tok_valid && o_tok_ready;
    assign w_ph = (r_ph == iptp_pkg::PH_START) ?
        ((i_tok.family == iptp_pkg::FAM_V6) ? iptp_pkg::PH_V6_BEGIN : iptp_pkg::PH_V4_DOT)
        : r_ph;
    assign w_fam = (r_ph == iptp_pkg::PH_START) ? i_tok.family : r_fam;

    always_comb begin
        logic [3:0] g0;
        logic [9:0] d0;
        logic [2:0] c0;
        logic e0, a0;
        g0 = (r_ph == iptp_pkg::PH_START) ? 4'd0 : r_gc;
        d0 = (r_ph == iptp_pkg::PH_START) ? 10'd0 : r_dec;
        c0 = (r_ph == iptp_pkg::PH_START) ? 3'd0 : r_dc;
        e0 = (r_ph == iptp_pkg::PH_START) ? 1'b0 : r_err;
        a0 = (r_ph == iptp_pkg::PH_START) ? 1'b1 : r_ad;
        n_ph = w_ph; n_gc = g0; n_err = e0; n_ad = a0; n_dec = d0; n_dc = c0;
        n_gv = (r_ph == iptp_pkg::PH_START) ? 1'b0 : r_gv;
        n_gp = (r_ph == iptp_pkg::PH_START) ? 4'd0 : r_gp;
        n_hex = (r_ph == iptp_pkg::PH_START) ? 16'd0 : r_hex;
        n_oi = (r_ph == iptp_pkg::PH_START) ? 3'd0 : r_oi;
        w_gw = 1'b0; w_gi = g0[2:0]; w_ow = 1'b0; w_oidx = '0; w_oval = d0[7:0];
        if (!i_tok.last && w_fam < 2'd2 && !e0) begin
            unique case (w_ph)
                iptp_pkg::PH_V6_BEGIN, iptp_pkg::PH_V6_GAP, iptp_pkg::PH_V6_COLON: begin
                    if (w_ph == iptp_pkg::PH_V6_BEGIN && i_tok.colon)
                        n_ph = iptp_pkg::PH_V6_LEAD;
                    else if (w_ph == iptp_pkg::PH_V6_COLON && i_tok.colon && !n_gv) begin
                        n_gv = 1'b1; n_gp = g0; n_ph = iptp_pkg::PH_V6_GAP;
                    end else if (!i_tok.colon && !i_tok.hex[4]) begin
                        if (g0 >= 4'd8) n_err = 1'b1;
                        else begin
                            n_hex = {12'd0, i_tok.hex[3:0]}; n_dc = 3'd1;
                            n_ad = i_tok.dig; n_dec = i_tok.dig ? 10'(i_tok.hex) : 10'd0;
                            n_ph = iptp_pkg::PH_V6_DIGITS;
                        end
                    end else n_err = 1'b1;
                end
                iptp_pkg::PH_V6_LEAD: begin
                    if (i_tok.colon) begin
                        n_gv = 1'b1; n_gp = 4'd0; n_ph = iptp_pkg::PH_V6_GAP;
                    end else n_err = 1'b1;
                end
                iptp_pkg::PH_V6_DIGITS: begin
                    if (!i_tok.hex[4]) begin
                        if (c0 >= 3'd4) n_err = 1'b1;
                        else begin
                            n_hex = {r_hex[11:0], i_tok.hex[3:0]};
                            n_dc = c0 + 3'd1;
                            if (!i_tok.dig) n_ad = 1'b0;
                            if (a0 && i_tok.dig && n_dc <= 3'd3)
                                n_dec = 10'(d0 * 10'd10 + 10'(i_tok.hex));
                        end
                    end else if (i_tok.colon) begin
                        w_gw = 1'b1; n_gc = g0 + 4'd1; n_ph = iptp_pkg::PH_V6_COLON;
                    end else if (i_tok.dot && a0 && g0 <= 4'd6
                                 && iptp_pkg::part_ok(d0, c0)) begin
                        w_ow = 1'b1; w_oidx = 2'd0; n_oi = 3'd1;
                        n_ph = iptp_pkg::PH_V4_DOT;
                    end else n_err = 1'b1;
                end
                iptp_pkg::PH_V4_DOT: begin
                    if (i_tok.dig) begin
                        n_dec = 10'(i_tok.hex); n_dc = 3'd1; n_ph = iptp_pkg::PH_V4_DIGITS;
                    end else n_err = 1'b1;
                end
                iptp_pkg::PH_V4_DIGITS: begin
                    if (i_tok.dig) begin
                        if (c0 >= 3'd3) n_err = 1'b1;
                        else begin
                            n_dec = 10'(d0 * 10'd10 + 10'(i_tok.hex)); n_dc = c0 + 3'd1;
                        end
                    end else if (i_tok.dot && n_oi < 3'd3 && iptp_pkg::part_ok(d0, c0)) begin
                        w_ow = 1'b1; w_oidx = n_oi[1:0]; n_oi = n_oi + 3'd1;
                        n_ph = iptp_pkg::PH_V4_DOT;
                    end else n_err = 1'b1;
                end
                default: n_err = 1'b1;
            endcase
        end
        // end of text: judge and snapshot
        n_fst = iptp_pkg::ST_OK; n_fgc = g0;
        w_v4 = {r_oct[0], r_oct[1], r_oct[2], d0[7:0]};
        for (int k = 0; k < 8; k++) w_fg[k] = r_grp[k];
        if (w_fam >= 2'd2) n_fst = iptp_pkg::ST_FAM;
        else if (e0) n_fst = iptp_pkg::ST_BAD;
        else if (w_ph == iptp_pkg::PH_V4_DIGITS) begin
            if (r_oi != 3'd3 || !iptp_pkg::part_ok(d0, c0)) n_fst = iptp_pkg::ST_BAD;
            else if (w_fam == iptp_pkg::FAM_V6) begin
                if (g0 > 4'd6) n_fst = iptp_pkg::ST_BAD;
                else begin
                    w_fg[g0[2:0]] = {r_oct[0], r_oct[1]};
                    w_fg[3'(g0 + 4'd1)] = {r_oct[2], d0[7:0]};
                    n_fgc = g0 + 4'd2;
                end
            end
        end else if (w_fam != iptp_pkg::FAM_V6) n_fst = iptp_pkg::ST_BAD;
        else if (w_ph == iptp_pkg::PH_V6_DIGITS) begin
            w_fg[g0[2:0]] = r_hex; n_fgc = g0 + 4'd1;
        end else if (w_ph != iptp_pkg::PH_V6_GAP) n_fst = iptp_pkg::ST_BAD;
        if (n_fst == iptp_pkg::ST_OK && !(w_fam == iptp_pkg::FAM_V4)) begin
            if (n_gv ? (n_fgc >= 4'd8) : (n_fgc != 4'd8)) n_fst = iptp_pkg::ST_BAD;
        end
        n_fv = r_fv;
        if (w_adv) n_fv = w_go && i_tok.last;
    end

    always_comb begin
        w_fill = 4'd8 - r_fgc; w_j = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (r_fgv && 4'(i) >= r_fgp && 4'(i) < r_fgp + w_fill)
                w_addr[127-16*i -: 16] = 16'd0;
            else begin
                w_addr[127-16*i -: 16] = r_fg[w_j[2:0]];
                w_j = w_j + 4'd1;
            end
        end
        w_fin_ok = (r_fst == iptp_pkg::ST_OK);
    end

    assign o_valid = r_fv;
    assign o_status = r_fst;
    assign o_address_high = (!w_fin_ok || r_f4) ? 64'd0 : w_addr[127:64];
    assign o_address_low = !w_fin_ok ? 64'd0 : (r_f4 ? {32'd0, r_v4} : w_addr[63:0]);

    always_ff @(posedge i_clk) begin
        if (w_go && w_gw) r_grp[w_gi] <= r_hex;
        if (w_go && w_ow) r_oct[w_oidx] <= w_oval;
        if (w_go && i_tok.last) begin
            r_fst <= n_fst; r_fgc <= n_fgc; r_fgp <= n_gp; r_fgv <= n_gv;
            r_f4 <= (w_fam == iptp_pkg::FAM_V4); r_v4 <= w_v4;
            for (int k = 0; k < 8; k++) r_fg[k] <= w_fg[k];
        end
        if (w_go && !i_tok.last) begin
            r_hex <= n_hex; r_dec <= n_dec;
        end
        if (!i_rst_n) begin
            r_ph <= iptp_pkg::PH_START; r_gc <= '0; r_gv <= 1'b0; r_gp <= '0;
            r_err <= 1'b0; r_ad <= 1'b1; r_dc <= '0; r_oi <= '0; r_fam <= '0;
            r_fv <= 1'b0;
        end else begin
            r_fv <= n_fv;
            if (w_go) begin
                if (i_tok.last) r_ph <= iptp_pkg::PH_START;
                else begin
                    r_ph <= n_ph; r_gc <= n_gc; r_gv <= n_gv; r_gp <= n_gp;
                    r_err <= n_err; r_ad <= n_ad; r_dc <= n_dc; r_oi <= n_oi;
                    r_fam <= w_fam;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(o_status)) else $error("result lost");
    a_gc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gc <= 4'd8) else $error("group count");
    a_oi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oi <= 3'd3) else $error("octet index");
    a_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != iptp_pkg::ST_OK) |->
        (o_address_high == 64'd0 && o_address_low == 64'd0)) else $error("addr");
`endif
endmodule
`default_nettype wire

FILE: sv/ip_address_text_parser.sv
// A text_end beat is registered in the input queue, then judged when it leaves the queue
// and the finish register is free; o_valid rises as the result is registered there.
// Throughput: one character beat per cycle; the parse update on small registers is the
// per-cycle step. Only a text_end beat waits on a held result.
// Reset: synchronous active low; clears the queue, parse phase and output valid.
`default_nettype none
module ip_address_text_parser (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire  [7:0]  i_character,
    input  wire         i_text_end,
    input  wire  [1:0]  i_family,
    input  wire         i_valid,
    output logic        o_ready,
    output logic [1:0]  o_status,
    output logic [63:0] o_address_high,
    output logic [63:0] o_address_low,
    output logic        o_valid,
    input  wire         i_ready
);
    iptp_pkg::t_tok w_tok;
    logic w_tv, w_tr;

    iptp_front u_front (
        .i_clk, .i_rst_n, .i_character, .i_text_end, .i_family, .i_valid, .o_ready,
        .o_tok(w_tok), .o_tok_valid(w_tv), .i_tok_ready(w_tr)
    );

    iptp_back u_back (
        .i_clk, .i_rst_n, .i_tok(w_tok), .i_tok_valid(w_tv), .o_tok_ready(w_tr),
        .o_status, .o_address_high, .o_address_low, .o_valid, .i_ready
    );
endmodule
`default_nettype wire

FILE: dv/testbench.sv
`default_nettype none
module testbench;
    localparam int N_RANDOM = 500;

    typedef struct {
        logic [1:0]  status;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
    } t_addr_result;

    // IPv4/IPv6 text parser prediction; holds the expected results in order
    class addr_scoreboard;
        t_addr_result pending[$];
        int           fail_count;
        logic [15:0]  groups[8];
        logic [7:0]   octets[4];
        int unsigned  n_groups, gap_at, hex_acc, dec_acc, n_digits, n_octets;
        bit           has_gap, only_dec, bad;
        iptp_pkg::t_phase phase;
        logic [1:0]   fam;

        function new();
            fail_count = 0;
            phase = iptp_pkg::PH_START;
            fam = iptp_pkg::FAM_V4;
            clear_text();
        endfunction

        function void clear_text();
            foreach (groups[i]) groups[i] = '0;
            foreach (octets[i]) octets[i] = '0;
            n_groups = 0; has_gap = 0; gap_at = 0; hex_acc = 0; dec_acc = 0;
            n_digits = 0; only_dec = 1; n_octets = 0; bad = 0;
        endfunction

        function bit part_good(int unsigned v, int unsigned n);
            if (n < 1 || n > 3 || v > 255) return 0;
            if (n == 2 && v < 10) return 0;
            if (n == 3 && v < 100) return 0;
            return 1;
        endfunction

        function int unsigned hex_of(logic [7:0] c);
            logic [7:0] lc;
            lc = c | 8'h20;
            if (c >= "0" && c <= "9") return c - "0";
            if (lc >= "a" && lc <= "f") return lc - "a" + 10;
            return 16;
        endfunction

        function void open_group(int unsigned h);
            if (n_groups >= 8) begin
                bad = 1;
                return;
            end
            hex_acc = h; n_digits = 1; only_dec = (h < 10);
            dec_acc = (h < 10) ? h : 0;
            phase = iptp_pkg::PH_V6_DIGITS;
        endfunction

        function void close_group();
            groups[n_groups % 8] = hex_acc[15:0];
            n_groups++;
        endfunction

        function void take(logic [7:0] c);
            int unsigned h;
            bit dg;
            h = hex_of(c);
            dg = (c >= "0" && c <= "9");
            case (phase)
                iptp_pkg::PH_V6_BEGIN: begin
                    if (c == iptp_pkg::CH_COLON) phase = iptp_pkg::PH_V6_LEAD;
                    else if (h < 16) open_group(h);
                    else bad = 1;
                end
                iptp_pkg::PH_V6_LEAD: begin
                    if (c == iptp_pkg::CH_COLON) begin
                        has_gap = 1; gap_at = 0; phase = iptp_pkg::PH_V6_GAP;
                    end else bad = 1;
                end
                iptp_pkg::PH_V6_GAP, iptp_pkg::PH_V6_COLON: begin
                    if (c == iptp_pkg::CH_COLON && phase == iptp_pkg::PH_V6_COLON
                        && !has_gap) begin
                        has_gap = 1; gap_at = n_groups; phase = iptp_pkg::PH_V6_GAP;
                    end else if (c != iptp_pkg::CH_COLON && h < 16) open_group(h);
                    else bad = 1;
                end
                iptp_pkg::PH_V6_DIGITS: begin
                    if (h < 16) begin
                        if (n_digits >= 4) bad = 1;
                        else begin
                            hex_acc = ((hex_acc << 4) | h) & 16'hffff;
                            n_digits++;
                            if (h >= 10) only_dec = 0;
                            if (only_dec && n_digits <= 3) dec_acc = dec_acc * 10 + h;
                        end
                    end else if (c == iptp_pkg::CH_COLON) begin
                        close_group();
                        phase = iptp_pkg::PH_V6_COLON;
                    end else if (c == iptp_pkg::CH_DOT && only_dec && n_groups <= 6 &&
                                 part_good(dec_acc, n_digits)) begin
                        octets[0] = dec_acc[7:0]; n_octets = 1;
                        phase = iptp_pkg::PH_V4_DOT;
                    end else bad = 1;
                end
                iptp_pkg::PH_V4_DOT: begin
                    if (dg) begin
                        dec_acc = h; n_digits = 1; phase = iptp_pkg::PH_V4_DIGITS;
                    end else bad = 1;
                end
                iptp_pkg::PH_V4_DIGITS: begin
                    if (dg) begin
                        if (n_digits >= 3) bad = 1;
                        else begin
                            dec_acc = dec_acc * 10 + h;
                            n_digits++;
                        end
                    end else if (c == iptp_pkg::CH_DOT && n_octets < 3 &&
                                 part_good(dec_acc, n_digits)) begin
                        octets[n_octets % 4] = dec_acc[7:0];
                        n_octets++;
                        phase = iptp_pkg::PH_V4_DOT;
                    end else bad = 1;
                end
                default: bad = 1;
            endcase
        endfunction

        function t_addr_result finish_text();
            t_addr_result r;
            logic [15:0] w[8];
            int unsigned fill, j;
            r.status = iptp_pkg::ST_OK; r.addr_high = '0; r.addr_low = '0;
            if (fam >= 2) begin
                r.status = iptp_pkg::ST_FAM;
                return r;
            end
            r.status = iptp_pkg::ST_BAD;
            if (bad) return r;
            if (phase == iptp_pkg::PH_V4_DIGITS) begin
                if (n_octets != 3 || !part_good(dec_acc, n_digits)) return r;
                octets[3] = dec_acc[7:0];
                if (fam == iptp_pkg::FAM_V4) begin
                    r.status = iptp_pkg::ST_OK;
                    r.addr_low = {32'd0, octets[0], octets[1], octets[2], octets[3]};
                    return r;
                end
                if (n_groups > 6) return r;
                groups[n_groups % 8] = {octets[0], octets[1]};
                groups[(n_groups + 1) % 8] = {octets[2], octets[3]};
                n_groups += 2;
            end else if (fam != iptp_pkg::FAM_V6) return r;
            else if (phase == iptp_pkg::PH_V6_DIGITS) close_group();
            else if (phase != iptp_pkg::PH_V6_GAP) return r;
            if (has_gap ? n_groups >= 8 : n_groups != 8) return r;
            fill = 8 - n_groups;
            j = 0;
            for (int i = 0; i < 8; i++) begin
                if (has_gap && i >= gap_at && i < gap_at + fill) w[i] = '0;
                else begin
                    w[i] = groups[j % 8];
                    j++;
                end
            end
            r.status = iptp_pkg::ST_OK;
            r.addr_high = {w[0], w[1], w[2], w[3]};
            r.addr_low = {w[4], w[5], w[6], w[7]};
            return r;
        endfunction

        function void note_beat(logic [7:0] c, logic last, logic [1:0] f);
            if (phase == iptp_pkg::PH_START) begin
                clear_text();
                fam = f;
                phase = (f == iptp_pkg::FAM_V6) ? iptp_pkg::PH_V6_BEGIN : iptp_pkg::PH_V4_DOT;
            end
            if (last) begin
                pending.push_back(finish_text());
                clear_text();
                phase = iptp_pkg::PH_START;
            end else if (fam < 2 && !bad) take(c);
        endfunction

        task report(string what);
            $display("tb: mismatch %s", what);
            fail_count++;
        endtask

        task check_result(logic [1:0] st, logic [63:0] hi, logic [63:0] lo);
            t_addr_result e;
            if (pending.size() == 0) begin
                report("result with nothing expected");
                return;
            end
            e = pending.pop_front();
            if (st !== e.status) report($sformatf("status %0d exp %0d", st, e.status));
            if (hi !== e.addr_high)
                report($sformatf("address_high %h exp %h", hi, e.addr_high));
            if (lo !== e.addr_low) report($sformatf("address_low %h exp %h", lo, e.addr_low));
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic [7:0]  i_character = '0;
    logic        i_text_end = 0;
    logic [1:0]  i_family = '0;
    logic        i_valid = 0;
    logic        i_ready = 0;
    logic        o_ready, o_valid;
    logic [1:0]  o_status;
    logic [63:0] o_address_high, o_address_low;

    addr_scoreboard sb = new();
    bit  calm = 0;
    bit  done = 0;

    ip_address_text_parser i_dut (.*);

    always #5 i_clk = ~i_clk;

    // sink side: random stalls except in the calm stretch
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_status, o_address_high, o_address_low);
        i_ready <= calm ? 1'b1 : ($urandom_range(99) >= 24);
    end

    // valid stays up after a beat; it drops only on an idle cycle or a drain
    task send_beat(logic [7:0] c, logic last, logic [1:0] f);
        while (!calm && $urandom_range(99) < 24) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1; i_character <= c; i_text_end <= last; i_family <= f;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_beat(c, last, f);
    endtask

    task send_text(string s, logic [1:0] f);
        for (int i = 0; i < s.len(); i++) send_beat(s[i], 0, f);
        send_beat(8'($urandom_range(255)), 1, f);
    endtask

    function string rand_v4();
        string s;
        s = "";
        for (int k = 0; k < 4; k++)
            s = {s, (k ? "." : ""), $sformatf("%0d", $urandom_range(255))};
        return s;
    endfunction

    function string rand_v6();
        string s, g;
        int n, gap;
        bit tail;
        tail = $urandom_range(3) == 0;
        n = tail ? 6 : 8;
        gap = ($urandom_range(1)) ? $urandom_range(n - 1) : -1;
        s = "";
        for (int k = 0; k < n; k++) begin
            if (gap >= 0 && k >= gap && k < gap + $urandom_range(2, 1)) begin
                if (k == gap) s = {s, (k == 0) ? "::" : ":"};
                continue;
            end
            g = $sformatf($urandom_range(1) ? "%0h" : "%0H", $urandom_range(16'hffff));
            if ($urandom_range(3) == 0) g = $sformatf("%0h", $urandom_range(15));
            if (s.len() && s[s.len()-1] != ":") s = {s, ":"};
            s = {s, g};
        end
        if (tail) s = {s, (s.len() && s[s.len()-1] != ":") ? ":" : "", rand_v4()};
        return s;
    endfunction

    function string mangle(string s);
        string alpha = "0123456789abcdefABCDEFg.:x/ ";
        int p;
        if (s.len() == 0) return s;
        p = $urandom_range(s.len() - 1);
        case ($urandom_range(2))
            0: s[p] = alpha[$urandom_range(alpha.len() - 1)];
            1: s = s.substr(0, p - 1);
            default: s = {s, alpha.substr($urandom_range(alpha.len()-1), 0)};
        endcase
        return s;
    endfunction

    task wait_drain();
        int guard;
        guard = 0;
        i_valid <= 0;
        while (sb.pending.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        string s;
        logic [1:0] f;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes and each special case
        send_text("0.0.0.0", iptp_pkg::FAM_V4);
        send_text("255.255.255.255", iptp_pkg::FAM_V4);
        send_text("256.1.1.1", iptp_pkg::FAM_V4);
        send_text("01.2.3.4", iptp_pkg::FAM_V4);
        send_text("1.2.3", iptp_pkg::FAM_V4);
        send_text("", iptp_pkg::FAM_V4);
        send_text("", iptp_pkg::FAM_V6);
        send_text("::", iptp_pkg::FAM_V6);
        send_text("::1", iptp_pkg::FAM_V6);
        send_text("1::", iptp_pkg::FAM_V6);
        send_text("ffff:FFFF:0:1:2:3:4:5", iptp_pkg::FAM_V6);
        send_text("1:2:3:4:5:6:7:8:9", iptp_pkg::FAM_V6);
        send_text("1::2::3", iptp_pkg::FAM_V6);
        send_text("1:2:3:4::5:6:7:8", iptp_pkg::FAM_V6);
        send_text(":1::2", iptp_pkg::FAM_V6);
        send_text("1:2:", iptp_pkg::FAM_V6);
        send_text("12345::", iptp_pkg::FAM_V6);
        send_text("::ffff:192.168.1.255", iptp_pkg::FAM_V6);
        send_text("1:2:3:4:5:6:1.2.3.4", iptp_pkg::FAM_V6);
        send_text("1:2:3:4:5:6:7:1.2.3.4", iptp_pkg::FAM_V6);
        send_text("1.2.3.4", iptp_pkg::FAM_V6);
        send_text("1.2.3.4", 2'd2);
        send_text("::1", 2'd3);
        send_text("::1.2.3.4", iptp_pkg::FAM_V4);
        // sender holds off until the sink has caught up
        wait_drain();

        for (int n = 0; n < N_RANDOM; ) begin
            calm = (n >= 200 && n < 300);
            f = ($urandom_range(9) == 0) ? 2'($urandom_range(3, 2)) : 2'($urandom_range(1));
            case ($urandom_range(9))
                0: begin
                    s = "";
                    repeat ($urandom_range(12))
                        s = {s, $sformatf("%c", 8'($urandom_range(255, 1)))};
                end
                1, 2: s = mangle(f == iptp_pkg::FAM_V4 ? rand_v4() : rand_v6());
                default: s = (f == iptp_pkg::FAM_V4) ? rand_v4() : rand_v6();
            endcase
            send_text(s, f);
            n += s.len() + 1;
        end
        calm = 0;
        wait_drain();
        done = 1;
    end

    initial begin
        wait (done);
        if (sb.fail_count == 0 && sb.pending.size() == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire

FILE: ip_address_text_parser.f
sv/iptp_pkg.sv
sv/iptp_front.sv
sv/iptp_back.sv
sv/ip_address_text_parser.sv
dv/testbench.sv
